// File: src/lzs_decompressor_macros.svh
// Assertion macros shared by the LZS decompressor RTL.
`ifndef LZS_DECOMPRESSOR_MACROS_SVH
`define LZS_DECOMPRESSOR_MACROS_SVH

// Check on every rising clk edge, quiet while rst is high.
`define LZS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every rising clk edge, reset cycles included.
`define LZS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/lzs_pkg.sv
// Shared types, codes and constants of the LZS decompressor.
`timescale 1ns / 1ps

package lzs_pkg;

  // History window
  localparam int HistSize = 2048;
  localparam int HistAw   = $clog2(HistSize);

  // Parse phases
  typedef logic [2:0] phase_t;
  localparam phase_t PH_FLAG  = 3'd0;
  localparam phase_t PH_LIT   = 3'd1;
  localparam phase_t PH_OFFK  = 3'd2;
  localparam phase_t PH_OFF7  = 3'd3;
  localparam phase_t PH_OFF11 = 3'd4;
  localparam phase_t PH_LEN2  = 3'd5;
  localparam phase_t PH_LEN4  = 3'd6;
  localparam phase_t PH_NIB   = 3'd7;

  // Action raised by one parsed bit
  typedef logic [1:0] act_t;
  localparam act_t ACT_NONE = 2'd0;
  localparam act_t ACT_LIT  = 2'd1;
  localparam act_t ACT_COPY = 2'd2;
  localparam act_t ACT_END  = 2'd3;

  // Result of the bit step unit
  typedef struct packed {
    phase_t              phase;
    logic [3:0]          bits;
    logic [HistAw-1:0]   shift;
    act_t                act;
    logic [7:0]          val;
    logic [3:0]          cnt;
    logic                set_cp;
    logic [HistAw-1:0]   off;
  } step_t;

endpackage

// File: src/lzs_decompressor.sv
// LZS decompressor top level: bit sequencer, match copier and result buffer.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------------------
//   in      | input     | in_valid / in_stall  | in_byte
//   out     | output    | out_valid / out_stall| out_byte, byte_valid, run_last, stream_end
//
// The bit step unit takes a compressed byte one bit a cycle while no copy runs and
// a result can be pushed; each copied match byte takes a history read, then a write,
// and a flush step closes the item before the idle state takes the next byte. An
// end marker skips the remaining bits of its byte. The history memory port sets the
// copy rate. After reset a clearing pass writes zeros over all 2048 history
// entries; in_stall stays high for the whole pass. A held out_stall freezes the
// sequencer at its next result. The last result of each byte is released only when
// the byte is done.
`timescale 1ns / 1ps
`include "lzs_decompressor_macros.svh"

module lzs_decompressor (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       run_last,
  output logic       stream_end
);

  localparam int Aw = lzs_pkg::HistAw;

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_BIT   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_WR    = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0]      state;
  logic [Aw-1:0]   clr_addr;
  logic [7:0]      byte_q;
  logic [3:0]      bits_left;
  lzs_pkg::phase_t phase;
  logic [3:0]      bits;
  logic [Aw-1:0]   shift;
  logic [Aw-1:0]   wp;
  logic [Aw-1:0]   cptr;
  logic [3:0]      cnt_q;

  // one held-back result, so run_last can be set on the last one
  logic            pend_valid;
  logic [7:0]      pend_byte;
  logic            pend_bv;
  logic            pend_end;

  lzs_pkg::step_t  st;
  logic [7:0]      rdata;

  logic            out_free;
  logic            can_push;
  logic            commit;
  logic            push_en;
  logic [7:0]      push_byte;
  logic            push_bv;
  logic            push_end;
  logic            flush_en;
  logic            xfer;
  logic            mem_we;
  logic [Aw-1:0]   mem_waddr;
  logic [7:0]      mem_wdata;
  logic            mem_re;

  lzs_bitstep u_step (
    .phase  (phase),
    .bits   (bits),
    .shift  (shift),
    .bit_in (byte_q[7]),
    .st     (st)
  );

  lzs_hist u_hist (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (cptr),
    .rdata (rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign can_push = !pend_valid || out_free;

  // control for this cycle
  always_comb begin
    commit    = 1'b0;
    push_en   = 1'b0;
    push_byte = 8'd0;
    push_bv   = 1'b0;
    push_end  = 1'b0;
    flush_en  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = wp;
    mem_wdata = rdata;
    mem_re    = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = 8'd0;
      end
      S_BIT: begin
        if (st.act == lzs_pkg::ACT_LIT) begin
          commit    = can_push;
          push_en   = can_push;
          push_byte = st.val;
          push_bv   = 1'b1;
          mem_we    = can_push;
          mem_wdata = st.val;
        end else if (st.act == lzs_pkg::ACT_END) begin
          commit   = can_push;
          push_en  = can_push;
          push_end = 1'b1;
        end else begin
          commit = 1'b1;
        end
      end
      S_RD: begin
        mem_re = 1'b1;
      end
      S_WR: begin
        push_en   = can_push;
        push_byte = rdata;
        push_bv   = 1'b1;
        mem_we    = can_push;
      end
      S_FLUSH: begin
        flush_en = pend_valid && out_free;
      end
      default: begin
      end
    endcase
  end

  assign xfer = (push_en && pend_valid) || flush_en;

  // sequencer and parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      bits_left <= 4'd0;
      phase     <= lzs_pkg::PH_FLAG;
      bits      <= 4'd0;
      shift     <= '0;
      wp        <= '0;
      cptr      <= '0;
      cnt_q     <= 4'd0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == {Aw{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            byte_q    <= in_byte;
            bits_left <= 4'd8;
            state     <= S_BIT;
          end
        end
        S_BIT: begin
          if (commit) begin
            phase     <= st.phase;
            bits      <= st.bits;
            shift     <= st.shift;
            byte_q    <= {byte_q[6:0], 1'b0};
            bits_left <= bits_left - 4'd1;
            if (st.set_cp) begin
              cptr <= wp - st.off;
            end
            if (st.act == lzs_pkg::ACT_LIT) begin
              wp <= wp + 1'b1;
            end
            if (st.act == lzs_pkg::ACT_END) begin
              // fresh stream, rest of this byte skipped
              wp    <= '0;
              cptr  <= '0;
              state <= S_FLUSH;
            end else if (st.act == lzs_pkg::ACT_COPY && st.cnt != 4'd0) begin
              cnt_q <= st.cnt;
              state <= S_RD;
            end else if (bits_left == 4'd1) begin
              state <= S_FLUSH;
            end
          end
        end
        S_RD: begin
          cptr  <= cptr + 1'b1;
          state <= S_WR;
        end
        S_WR: begin
          if (can_push) begin
            wp    <= wp + 1'b1;
            cnt_q <= cnt_q - 4'd1;
            if (cnt_q != 4'd1) begin
              state <= S_RD;
            end else if (bits_left == 4'd0) begin
              state <= S_FLUSH;
            end else begin
              state <= S_BIT;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid || out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // held-back result
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (push_en) begin
      pend_valid <= 1'b1;
    end else if (flush_en) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      pend_byte <= push_byte;
      pend_bv   <= push_bv;
      pend_end  <= push_end;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (xfer) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      out_byte   <= pend_byte;
      byte_valid <= pend_bv;
      stream_end <= pend_end;
      run_last   <= flush_en;
    end
  end

  // checks
  `LZS_ASSERT_ALWAYS(a_reset_clears, rst |=> (state == S_CLEAR), "reset must start the clear pass")
  `LZS_ASSERT(a_no_out_in_clear, (state == S_CLEAR) |-> !out_valid, "result during clear pass")
  `LZS_ASSERT(a_accept_empty, !in_stall |-> !pend_valid, "new byte taken with a result held back")
  `LZS_ASSERT(a_end_is_last, (out_valid && stream_end) |-> (run_last && !byte_valid), "end report not last or carries data")
  `LZS_ASSERT(a_copy_count, (state == S_RD) |-> (cnt_q != 4'd0), "history read with no bytes left to copy")

endmodule

// File: src/lzs_hist.sv
// 2048 x 8 history memory, one write port and one registered read port.
`timescale 1ns / 1ps

module lzs_hist (
  input  logic                       clk,
  input  logic                       we,
  input  logic [lzs_pkg::HistAw-1:0] waddr,
  input  logic [7:0]                 wdata,
  input  logic                       re,
  input  logic [lzs_pkg::HistAw-1:0] raddr,
  output logic [7:0]                 rdata
);

  logic [7:0] mem [lzs_pkg::HistSize];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/lzs_bitstep.sv
// Bit step unit: advances the LZS parser by one compressed bit.
`timescale 1ns / 1ps

module lzs_bitstep (
  input  lzs_pkg::phase_t            phase,
  input  logic [3:0]                 bits,
  input  logic [lzs_pkg::HistAw-1:0] shift,
  input  logic                       bit_in,
  output lzs_pkg::step_t             st
);

  logic [lzs_pkg::HistAw-1:0] sh;
  logic [3:0]                 bc;

  assign sh = {shift[lzs_pkg::HistAw-2:0], bit_in};
  assign bc = bits + 4'd1;

  always_comb begin
    st.phase  = phase;
    st.bits   = bc;
    st.shift  = sh;
    st.act    = lzs_pkg::ACT_NONE;
    st.val    = sh[7:0];
    st.cnt    = 4'd0;
    st.set_cp = 1'b0;
    st.off    = sh;
    case (phase)
      lzs_pkg::PH_FLAG: begin
        st.phase = bit_in ? lzs_pkg::PH_OFFK : lzs_pkg::PH_LIT;
        st.bits  = 4'd0;
        st.shift = '0;
      end
      lzs_pkg::PH_LIT: begin
        if (bc == 4'd8) begin
          st.act   = lzs_pkg::ACT_LIT;
          st.phase = lzs_pkg::PH_FLAG;
          st.bits  = 4'd0;
          st.shift = '0;
        end
      end
      lzs_pkg::PH_OFFK: begin
        st.phase = bit_in ? lzs_pkg::PH_OFF7 : lzs_pkg::PH_OFF11;
        st.bits  = 4'd0;
        st.shift = '0;
      end
      lzs_pkg::PH_OFF7: begin
        if (bc == 4'd7) begin
          st.bits  = 4'd0;
          st.shift = '0;
          if (sh == '0) begin
            // end marker
            st.act   = lzs_pkg::ACT_END;
            st.phase = lzs_pkg::PH_FLAG;
          end else begin
            st.set_cp = 1'b1;
            st.phase  = lzs_pkg::PH_LEN2;
          end
        end
      end
      lzs_pkg::PH_OFF11: begin
        if (bc == 4'd11) begin
          st.set_cp = 1'b1;
          st.phase  = lzs_pkg::PH_LEN2;
          st.bits   = 4'd0;
          st.shift  = '0;
        end
      end
      lzs_pkg::PH_LEN2: begin
        if (bc == 4'd2) begin
          if (sh[1:0] != 2'b11) begin
            st.act   = lzs_pkg::ACT_COPY;
            st.cnt   = {2'b00, sh[1:0]} + 4'd2;
            st.phase = lzs_pkg::PH_FLAG;
            st.bits  = 4'd0;
            st.shift = '0;
          end else begin
            // keep collecting into the same field
            st.phase = lzs_pkg::PH_LEN4;
          end
        end
      end
      lzs_pkg::PH_LEN4: begin
        if (bc == 4'd4) begin
          st.act   = lzs_pkg::ACT_COPY;
          st.bits  = 4'd0;
          st.shift = '0;
          if (sh[3:0] != 4'hF) begin
            st.cnt   = sh[3:0] - 4'd7;
            st.phase = lzs_pkg::PH_FLAG;
          end else begin
            st.cnt   = 4'd8;
            st.phase = lzs_pkg::PH_NIB;
          end
        end
      end
      lzs_pkg::PH_NIB: begin
        if (bc == 4'd4) begin
          st.act   = lzs_pkg::ACT_COPY;
          st.cnt   = sh[3:0];
          st.phase = (sh[3:0] == 4'hF) ? lzs_pkg::PH_NIB : lzs_pkg::PH_FLAG;
          st.bits  = 4'd0;
          st.shift = '0;
        end
      end
      default: begin
        st.phase = lzs_pkg::PH_FLAG;
        st.bits  = 4'd0;
        st.shift = '0;
      end
    endcase
  end

endmodule
